[design/csb_pkg.sv]
// Shared constants, register codes and types for the clipped sprite blitter.
// Depends on nothing; every other design file imports it.
package csb_pkg;

  // Sizing
  localparam int MAX_DIM       = 4096;
  localparam int PALETTE_DEPTH = 256;

  localparam int CNT_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = 13;
  localparam int ORG_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int INDEX_W    = 8;
  localparam int ADDR_W     = 24;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PAL_AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  // Width that holds both a clamped sprite size and a counter plus one
  localparam int SZ_W       = (DIM_W > CNT_W + 1) ? DIM_W : CNT_W + 1;
  // Width of a destination column or row (origin plus counter, with carry)
  localparam int POS_W      = ((ORG_W > CNT_W) ? ORG_W : CNT_W) + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = CFG_IDX_W'(6);

  // Item opcodes
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  // Configuration register file contents
  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] dest_height;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic             palette_mode;
  } cfg_t;

  // Destination position of the current source pixel
  typedef struct packed {
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] dy;
    logic             last;
  } pos_t;

  // Contents of the input stage register
  typedef struct packed {
    logic               pixel;
    logic [COLOR_W-1:0] color;
    logic               pal_hit;
    pos_t               pos;
  } stage_t;

endpackage

[design/csb_palette.sv]
// Palette memory: one write port, one registered read port.
// Depends on csb_pkg for depth and widths.
module csb_palette (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [csb_pkg::PAL_AW-1:0]    wr_addr,
  input  logic [csb_pkg::COLOR_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [csb_pkg::PAL_AW-1:0]    rd_addr,
  output logic [csb_pkg::COLOR_W-1:0]   rd_data
);
  import csb_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

  // Store a palette entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data; hold it between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/csb_raster.sv]
// Raster column and row counters and destination coordinate of each pixel.
// Depends on csb_pkg for widths and the configuration and position types.
module csb_raster (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  csb_pkg::cfg_t  cfg,
  output csb_pkg::pos_t  pos
);
  import csb_pkg::*;

  localparam logic [SZ_W-1:0] MAX_DIM_V = SZ_W'(MAX_DIM);
  localparam logic [SZ_W-1:0] ONE_V     = SZ_W'(1);

  logic [CNT_W-1:0] col_counter, row_counter;
  logic [SZ_W-1:0]  sw, sh, sw_raw, sh_raw, col_inc, row_inc;
  logic             last_col, last_row;

  // Clamp the sprite size into 1..MAX_DIM
  always_comb begin
    sw_raw = SZ_W'(cfg.src_width);
    sh_raw = SZ_W'(cfg.src_height);
    if (sw_raw == '0) begin
      sw = ONE_V;
    end else if (sw_raw > MAX_DIM_V) begin
      sw = MAX_DIM_V;
    end else begin
      sw = sw_raw;
    end
    if (sh_raw == '0) begin
      sh = ONE_V;
    end else if (sh_raw > MAX_DIM_V) begin
      sh = MAX_DIM_V;
    end else begin
      sh = sh_raw;
    end
  end

  // Detect row and sprite end
  assign col_inc  = SZ_W'(col_counter) + ONE_V;
  assign row_inc  = SZ_W'(row_counter) + ONE_V;
  assign last_col = (col_inc >= sw);
  assign last_row = (row_inc >= sh);

  // Map sprite position into the frame
  assign pos.dx   = POS_W'(cfg.origin_x) + POS_W'(col_counter);
  assign pos.dy   = POS_W'(cfg.origin_y) + POS_W'(row_counter);
  assign pos.last = last_col && last_row;

  // Advance the counters on each source pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
    end else if (step) begin
      if (last_col) begin
        col_counter <= '0;
        if (last_row) begin
          row_counter <= '0;
        end else begin
          row_counter <= row_counter + CNT_W'(1);
        end
      end else begin
        col_counter <= col_counter + CNT_W'(1);
      end
    end
  end

endmodule

[design/csb_result.sv]
// Clip, alpha test, color select and address, then the output register.
// Depends on csb_pkg for the stage and configuration types.
module csb_result (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          s1_valid,
  input  csb_pkg::stage_t               s1,
  input  logic [csb_pkg::COLOR_W-1:0]   pal_data,
  input  csb_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output logic                          write_enable,
  output logic [csb_pkg::ADDR_W-1:0]    dest_address,
  output logic [csb_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          sprite_done
);
  import csb_pkg::*;

  logic [COLOR_W-1:0]       pix;
  logic                     visible, inside_frame, we;
  logic [POS_W+DIM_W-1:0]   row_base;
  logic [ADDR_W-1:0]        addr;

  // Pick the color; test alpha in direct-color mode only
  always_comb begin
    if (cfg.palette_mode) begin
      pix     = s1.pal_hit ? pal_data : '0;
      visible = 1'b1;
    end else begin
      pix     = s1.color;
      visible = (s1.color[COLOR_W-1:COLOR_W-8] != 8'd0);
    end
  end

  // Clip against the frame and form the linear address
  assign inside_frame = (s1.pos.dx < POS_W'(cfg.dest_width)) &&
                        (s1.pos.dy < POS_W'(cfg.dest_height));
  assign we       = s1.pixel && visible && inside_frame;
  assign row_base = s1.pos.dy * (POS_W+DIM_W)'(cfg.dest_width);
  assign addr     = s1.pos.dx[ADDR_W-1:0] + row_base[ADDR_W-1:0];

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // Output payload; zero address and color when nothing is written
  always_ff @(posedge clk) begin
    if (advance) begin
      write_enable <= we;
      dest_address <= we ? addr : '0;
      pixel_color  <= we ? pix : '0;
      sprite_done  <= s1.pixel && s1.pos.last;
    end
  end

endmodule

[design/clipped_sprite_blitter.sv]
// Clipped sprite blitter: places raster-order sprite pixels into a frame.
// Pipeline: input stage, then output stage, between input transaction and result.
// Throughput: one item per cycle while the result channel does not stall; the palette read
//   is registered and lines up with the input stage, so palette writes and pixel reads can alternate freely.
// Reset: counters cleared, configuration back to defaults, pipeline emptied;
//   palette contents are kept and hold nothing defined until written.
module clipped_sprite_blitter (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes
  input  logic                            cfg_write,
  input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [csb_pkg::COLOR_W-1:0]     color_word,
  input  logic [csb_pkg::INDEX_W-1:0]     color_index,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            write_enable,
  output logic [csb_pkg::ADDR_W-1:0]      dest_address,
  output logic [csb_pkg::COLOR_W-1:0]     pixel_color,
  output logic                            sprite_done
);
  import csb_pkg::*;

  cfg_t               cfg;
  pos_t               pos;
  stage_t             s1;
  logic               s1_valid;
  logic               advance, accept, pal_hit;
  logic [COLOR_W-1:0] pal_data;

  // Handshake: output stage moves when empty or drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;
  assign pal_hit  = (32'(color_index) < PALETTE_DEPTH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_width   <= DIM_W'(640);
      cfg.dest_height  <= DIM_W'(480);
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.src_width    <= DIM_W'(8);
      cfg.src_height   <= DIM_W'(8);
      cfg.palette_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:   cfg.dest_width   <= cfg_data[DIM_W-1:0];
        REG_DEST_HEIGHT:  cfg.dest_height  <= cfg_data[DIM_W-1:0];
        REG_ORIGIN_X:     cfg.origin_x     <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data[ORG_W-1:0];
        REG_SRC_WIDTH:    cfg.src_width    <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT:   cfg.src_height   <= cfg_data[DIM_W-1:0];
        REG_PALETTE_MODE: cfg.palette_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Raster position
  csb_raster u_raster (
    .clk  (clk),
    .rst  (rst),
    .step (accept && (op == OP_PIXEL)),
    .cfg  (cfg),
    .pos  (pos)
  );

  // Palette store and lookup
  csb_palette u_palette (
    .clk     (clk),
    .wr_en   (accept && (op == OP_PAL_WRITE) && pal_hit),
    .wr_addr (color_index[PAL_AW-1:0]),
    .wr_data (color_word),
    .rd_en   (accept && (op == OP_PIXEL)),
    .rd_addr (color_index[PAL_AW-1:0]),
    .rd_data (pal_data)
  );

  // Input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pixel   <= (op == OP_PIXEL);
      s1.color   <= color_word;
      s1.pal_hit <= pal_hit;
      s1.pos     <= pos;
    end
  end

  // Result logic and output register
  csb_result u_result (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .pal_data     (pal_data),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .write_enable (write_enable),
    .dest_address (dest_address),
    .pixel_color  (pixel_color),
    .sprite_done  (sprite_done)
  );

  // A stalled input stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input stage dropped a stalled transaction");

  // Input backpressure only when both stages are full and blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled while pipeline had room");

  // A result without a write carries zero address and color
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> dest_address == '0 && pixel_color == '0)
    else $error("non-write result carries address or color");

endmodule
